[design/tisp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tisp_pkg
// Shared types and codes for the telnet IAC stream parser.
// ---------------------------------------------------------------------------
package tisp_pkg;

	// Telnet protocol byte codes
	localparam logic [7:0] CODE_IAC  = 8'd255;
	localparam logic [7:0] CODE_SB   = 8'd250;
	localparam logic [7:0] CODE_WILL = 8'd251;
	localparam logic [7:0] CODE_DONT = 8'd254;
	// Lowest command code in the standard command range
	localparam logic [7:0] CODE_FIRST_CMD = 8'd236;

	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 3;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	// Parser phases
	typedef enum logic [2:0] {
		PH_DATA    = 3'd0,
		PH_CMD     = 3'd1,
		PH_NEGO    = 3'd2,
		PH_SUBOPT  = 3'd3,
		PH_SUBDATA = 3'd4,
		PH_SUBTERM = 3'd5
	} phase_t;

	// Event kinds reported on the output channel
	typedef enum logic [KIND_W-1:0] {
		KIND_DATA    = 3'd0,
		KIND_NEGO    = 3'd1,
		KIND_CMD     = 3'd2,
		KIND_SUBDATA = 3'd3,
		KIND_SUBEND  = 3'd4
	} kind_t;

	// Byte held in the input register
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	// One parse result, valid when the byte produced an event
	typedef struct packed {
		logic              valid;
		kind_t             event_kind;
		logic [BYTE_W-1:0] code_value;
		logic [BYTE_W-1:0] option_code;
	} result_t;

	// True for WILL, WONT, DO and DONT
	function automatic logic is_nego_verb(input logic [BYTE_W-1:0] b);
		return (b >= CODE_WILL) && (b <= CODE_DONT);
	endfunction

endpackage

[design/telnet_iac_stream_parser.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// telnet_iac_stream_parser
// Splits a received telnet byte stream into data bytes and IAC events.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per transfer in tdata[7:0].
//   m_axis carries zero or one event per input byte: tuser[2:0] is the event
//   kind (data, negotiation, command, sub data, sub end), tdata[7:0] the
//   code byte and tdata[15:8] the option byte (zero for data and commands).
//   Bytes that open or continue an IAC sequence produce no event.
//   Each byte passes the input register, then the result register, before
//   its event can transfer on m_axis. Throughput: one byte per cycle while
//   m_axis_tready is high; the phase decode is a single short step between
//   the two registers.
//   Reset (arst_n low) empties both registers and returns the parser to the
//   plain data phase with the held verb and sub option cleared.
//   When the receiver stalls, the result register holds its event and the
//   input register keeps one more byte; s_axis_tready drops once both are
//   full and rises in the cycle m_axis_tready returns.
// ---------------------------------------------------------------------------
module telnet_iac_stream_parser
	import tisp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] code_value, [15:8] option_code
	output logic [KIND_W-1:0]     m_axis_tuser    // [2:0] event_kind
);

	in_item_t item;
	result_t  res;
	logic     advance;

	tisp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata[BYTE_W-1:0]),
		.advance  (advance),
		.item     (item)
	);

	tisp_parser u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.advance (advance),
		.res     (res)
	);

	tisp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

[design/tisp_in_stage.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tisp_in_stage
// Input register: holds one received byte until the parser consumes it.
// ---------------------------------------------------------------------------
module tisp_in_stage
	import tisp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    in_byte,
	input  logic                 advance,   // parser stage can move this cycle
	output in_item_t             item
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Free slot, or the held byte leaves this cycle
	assign in_ready = !valid_s1 || advance;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign item.valid   = valid_s1;
	assign item.rx_byte = byte_s1;

endmodule

[design/tisp_parser.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tisp_parser
// Phase tracking and decode of IAC sequences, one byte per transfer.
// ---------------------------------------------------------------------------
module tisp_parser
	import tisp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic     advance,
	output result_t  res
);

	phase_t            phase_q;
	phase_t            phase_nxt;
	logic [BYTE_W-1:0] held_cmd_q;
	logic [BYTE_W-1:0] sub_opt_q;
	logic              fire;
	logic [BYTE_W-1:0] b;

	assign fire = item.valid && advance;
	assign b    = item.rx_byte;

	// Next phase
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_CMD: begin
				if (is_nego_verb(b)) begin
					phase_nxt = PH_NEGO;
				end else if (b == CODE_SB) begin
					phase_nxt = PH_SUBOPT;
				end else begin
					phase_nxt = PH_DATA;
				end
			end
			PH_NEGO:    phase_nxt = PH_DATA;
			PH_SUBOPT:  phase_nxt = PH_SUBDATA;
			PH_SUBDATA: phase_nxt = (b == CODE_IAC) ? PH_SUBTERM : PH_SUBDATA;
			PH_SUBTERM: phase_nxt = PH_DATA;
			default:    phase_nxt = (b == CODE_IAC) ? PH_CMD : PH_DATA;
		endcase
	end

	// Result for the current byte
	always_comb begin
		res.valid       = 1'b0;
		res.event_kind  = KIND_DATA;
		res.code_value  = b;
		res.option_code = '0;
		case (phase_q)
			PH_CMD: begin
				if (!is_nego_verb(b) && (b != CODE_SB)) begin
					res.valid      = fire;
					res.event_kind = KIND_CMD;
				end
			end
			PH_NEGO: begin
				res.valid       = fire;
				res.event_kind  = KIND_NEGO;
				res.code_value  = held_cmd_q;
				res.option_code = b;
			end
			PH_SUBOPT: begin
				res.valid = 1'b0;
			end
			PH_SUBDATA: begin
				res.valid       = fire && (b != CODE_IAC);
				res.event_kind  = KIND_SUBDATA;
				res.option_code = sub_opt_q;
			end
			PH_SUBTERM: begin
				res.valid       = fire;
				res.event_kind  = KIND_SUBEND;
				res.option_code = sub_opt_q;
			end
			default: begin
				res.valid = fire && (b != CODE_IAC);
			end
		endcase
	end

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
		end else if (fire) begin
			phase_q <= phase_nxt;
		end
	end

	// Held verb and open subnegotiation option
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cmd_q <= '0;
			sub_opt_q  <= '0;
		end else if (fire) begin
			if (phase_q == PH_CMD && is_nego_verb(b)) begin
				held_cmd_q <= b;
			end
			if (phase_q == PH_SUBOPT) begin
				sub_opt_q <= b;
			end
		end
	end

	// Option byte is captured and sub data follows
	a_subopt_capture: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_SUBOPT |=> phase_q == PH_SUBDATA && sub_opt_q == $past(b))
		else $error("sub option not captured");

	// A negotiation option always yields the held verb
	a_nego_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_NEGO |-> res.valid && res.code_value == held_cmd_q)
		else $error("negotiation result missing");

	// Without a transfer the phase holds
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q))
		else $error("phase moved without transfer");

endmodule

[design/tisp_out_stage.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tisp_out_stage
// Result register feeding the output channel.
// ---------------------------------------------------------------------------
module tisp_out_stage
	import tisp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  result_t                res,
	output logic                   advance,   // register can take a new result
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_DATA_W-1:0]  out_data,
	output logic [KIND_W-1:0]      out_user
);

	logic              valid_s2;
	kind_t             kind_s2;
	logic [BYTE_W-1:0] code_s2;
	logic [BYTE_W-1:0] opt_s2;

	assign advance = !valid_s2 || out_ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_s2 <= res.event_kind;
			code_s2 <= res.code_value;
			opt_s2  <= res.option_code;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = {opt_s2, code_s2};
	assign out_user  = kind_s2;

endmodule
